FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; keypad_matrix_scanner includes them.
// No dependencies; the module that includes them must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising clock edge, also while reset is held.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/kms_pkg.sv
// Package for the keypad matrix scanner: field widths, key codes,
// table modes, configuration indexes and the 3x5x8 character table.
`default_nettype none

package kms_pkg;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 3;
    localparam int CNT_W   = 4;
    localparam int CODE_W  = 8;
    localparam int DRIVE_W = 7;
    localparam int HOLD_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] CODE_SHIFT = 8'h16;
    localparam logic [CODE_W-1:0] CODE_CAPS  = 8'h04;

    localparam logic [1:0] MODE_LOWER   = 2'd0;
    localparam logic [1:0] MODE_UPPER   = 2'd1;
    localparam logic [1:0] MODE_SHIFTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET   = 16'd300;
    localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 4'd4;

    localparam logic [CODE_W-1:0] CHAR_TABLE [0:2][0:4][0:7] = '{
        '{
            '{8'h03, 8'h01, 8'h02, 8'h61, 8'h62, 8'h63, 8'h64, 8'h00},
            '{8'h6B, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h00},
            '{8'h72, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h00},
            '{8'h79, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h00},
            '{8'h15, 8'h7A, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C, 8'h00}
        },
        '{
            '{8'h03, 8'h01, 8'h02, 8'h41, 8'h42, 8'h43, 8'h44, 8'h00},
            '{8'h4B, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h00},
            '{8'h52, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h00},
            '{8'h59, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h00},
            '{8'h15, 8'h5A, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C, 8'h00}
        },
        '{
            '{8'h03, 8'h01, 8'h02, 8'h31, 8'h32, 8'h33, 8'h34, 8'h00},
            '{8'h40, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h00},
            '{8'h22, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h11, 8'h00},
            '{8'h14, 8'h1B, 8'h2C, 8'h2E, 8'h3F, 8'h13, 8'h3A, 8'h00},
            '{8'h15, 8'h09, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C, 8'h00}
        }
    };

endpackage

`default_nettype wire

FILE: hw/rtl/keypad_matrix_scanner.sv
// Keypad matrix scanner: each accepted row sample gives one registered result beat.
// Throughput is one sample per cycle; the scan state and the output register update
// in the same edge, and a new sample is taken whenever the output register is empty
// or its beat is taken in that cycle. The configuration port is always ready.
// Synchronous active-low reset returns the scan to column 0 in lower-case mode, loads
// holdoff 300 and threshold 4 and empties the output; uses kms_pkg, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module keypad_matrix_scanner
    import kms_pkg::*;
#(
    parameter int NUM_COLUMNS     = 7,
    parameter int CONFIRM_SAMPLES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ROW_W-1:0]     i_row_bits,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [DRIVE_W-1:0]        o_column_drive,
    output logic                      o_key_valid,
    output logic [CODE_W-1:0]         o_key_code,
    output logic [1:0]                o_table_mode,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [HOLD_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        PH_SCAN    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HOLD    = 2'd2
    } t_phase;

    localparam logic [CNT_W:0]   NUM_COLS_C = (CNT_W+1)'(NUM_COLUMNS);
    localparam logic [CNT_W-1:0] CONFIRM_C  = CNT_W'(CONFIRM_SAMPLES);

    logic [HOLD_W-1:0] r_holdoff_samples;
    logic [CNT_W-1:0]  r_threshold;

    t_phase            r_phase,         n_phase;
    logic [COL_W-1:0]  r_col,           n_col;
    logic [ROW_W-1:0]  r_first_sample,  n_first_sample;
    logic [ROW_W-1:0]  r_prev_sample,   n_prev_sample;
    logic [CNT_W-1:0]  r_confirm_count, n_confirm_count;
    logic [CNT_W-1:0]  r_match_count,   n_match_count;
    logic [HOLD_W-1:0] r_holdoff_count, n_holdoff_count;
    logic [1:0]        r_mode,          n_mode;

    logic                r_out_valid;
    logic [DRIVE_W-1:0]  r_column_drive;
    logic                r_key_valid,   n_key_valid;
    logic [CODE_W-1:0]   r_key_code,    n_key_code;
    logic [1:0]          r_table_mode;

    logic                in_accept;
    logic [CNT_W:0]      inc_col;
    logic [COL_W-1:0]    wrap_col;
    logic [2:0]          row_idx;
    logic [1:0]          mode_sel;
    logic [CODE_W-1:0]   table_code;
    logic                row_onehot;
    logic [HOLD_W-1:0]   hold_dec;
    logic [(1<<COL_W)-1:0] drive_full;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign inc_col  = {2'b00, r_col} + 5'd1;
    assign wrap_col = (inc_col >= NUM_COLS_C) ? '0 : inc_col[COL_W-1:0];

    always_comb begin
        priority if (r_first_sample[0]) begin
            row_idx = 3'd0;
        end else if (r_first_sample[1]) begin
            row_idx = 3'd1;
        end else if (r_first_sample[2]) begin
            row_idx = 3'd2;
        end else if (r_first_sample[3]) begin
            row_idx = 3'd3;
        end else if (r_first_sample[4]) begin
            row_idx = 3'd4;
        end else begin
            row_idx = 3'd0;
        end
    end

    assign mode_sel   = (r_mode > MODE_SHIFTED) ? MODE_LOWER : r_mode;
    assign table_code = CHAR_TABLE[mode_sel][row_idx][r_col];
    assign row_onehot = (i_row_bits != '0) && ((i_row_bits & (i_row_bits - 5'd1)) == '0);
    assign hold_dec   = (r_holdoff_count != '0) ? r_holdoff_count - 16'd1 : r_holdoff_count;

    always_comb begin
        n_phase         = r_phase;
        n_col           = r_col;
        n_first_sample  = r_first_sample;
        n_prev_sample   = r_prev_sample;
        n_confirm_count = r_confirm_count;
        n_match_count   = r_match_count;
        n_holdoff_count = r_holdoff_count;
        n_mode          = r_mode;
        n_key_valid     = 1'b0;
        n_key_code      = '0;

        unique case (r_phase)
            PH_HOLD: begin
                n_holdoff_count = hold_dec;
                if (hold_dec == '0) begin
                    n_phase = PH_SCAN;
                end
                n_col = '0;
            end
            PH_CONFIRM: begin
                n_match_count   = (i_row_bits == r_prev_sample) ? r_match_count + 4'd1
                                                                 : r_match_count;
                n_prev_sample   = i_row_bits;
                n_confirm_count = r_confirm_count + 4'd1;
                if (n_confirm_count >= CONFIRM_C) begin
                    if (n_match_count > r_threshold) begin
                        if (table_code == CODE_SHIFT) begin
                            n_mode = MODE_SHIFTED;
                        end else if (table_code == CODE_CAPS) begin
                            n_mode = MODE_UPPER;
                        end else begin
                            n_key_valid = 1'b1;
                            n_key_code  = table_code;
                            n_mode      = MODE_LOWER;
                        end
                        n_col           = '0;
                        n_holdoff_count = r_holdoff_samples;
                        n_phase         = (r_holdoff_samples == '0) ? PH_SCAN : PH_HOLD;
                    end else begin
                        n_col   = wrap_col;
                        n_phase = PH_SCAN;
                    end
                end
            end
            default: begin
                if (row_onehot) begin
                    n_first_sample  = i_row_bits;
                    n_prev_sample   = i_row_bits;
                    n_confirm_count = '0;
                    n_match_count   = '0;
                    n_phase         = PH_CONFIRM;
                end else begin
                    n_col   = wrap_col;
                    n_phase = PH_SCAN;
                end
            end
        endcase
    end

    assign drive_full = (1 << COL_W)'(1) << n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_samples <= HOLDOFF_RESET;
            r_threshold       <= THRESHOLD_RESET;
            r_phase           <= PH_SCAN;
            r_col             <= '0;
            r_first_sample    <= '0;
            r_prev_sample     <= '0;
            r_confirm_count   <= '0;
            r_match_count     <= '0;
            r_holdoff_count   <= '0;
            r_mode            <= MODE_LOWER;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HOLDOFF:   r_holdoff_samples <= i_cfg_data;
                    CFG_THRESHOLD: r_threshold       <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_phase         <= n_phase;
                r_col           <= n_col;
                r_first_sample  <= n_first_sample;
                r_prev_sample   <= n_prev_sample;
                r_confirm_count <= n_confirm_count;
                r_match_count   <= n_match_count;
                r_holdoff_count <= n_holdoff_count;
                r_mode          <= n_mode;
                r_column_drive  <= drive_full[DRIVE_W-1:0];
                r_key_valid     <= n_key_valid;
                r_key_code      <= n_key_code;
                r_table_mode    <= n_mode;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_drive = r_column_drive;
    assign o_key_valid    = r_key_valid;
    assign o_key_code     = r_key_code;
    assign o_table_mode   = r_table_mode;

    `ASSERT_CLK(a_accept_gives_beat, in_accept |=> r_out_valid)
    `ASSERT_CLK(a_key_returns_lower, (r_out_valid && r_key_valid) |-> (r_table_mode == MODE_LOWER))
    `ASSERT_CLK(a_no_key_zero_code, (r_out_valid && !r_key_valid) |-> (r_key_code == '0))
    `ASSERT_CLK(a_hold_on_column_zero, (r_phase == PH_HOLD) |-> (r_col == '0))
    `ASSERT_CLK(a_confirm_in_range, (r_phase == PH_CONFIRM) |-> (r_confirm_count < CONFIRM_C))
    `ASSERT_ALWAYS(a_reset_empties_output, !i_rst_n |=> !r_out_valid)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for keypad_matrix_scanner: drives row samples and register writes,
// predicts every result beat in a small scoreboard class and compares it field by field.
// Depends on kms_pkg and the scanner RTL.
module tb_top
    import kms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_COLS   = 7;
    localparam int CONFIRM_LEN = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [CODE_W-1:0] KEY_MAP [0:2][0:4][0:6] = '{
        '{
            '{8'h03, 8'h01, 8'h02, 8'h61, 8'h62, 8'h63, 8'h64},
            '{8'h6B, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A},
            '{8'h72, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71},
            '{8'h79, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78},
            '{8'h15, 8'h7A, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C}
        },
        '{
            '{8'h03, 8'h01, 8'h02, 8'h41, 8'h42, 8'h43, 8'h44},
            '{8'h4B, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A},
            '{8'h52, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51},
            '{8'h59, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58},
            '{8'h15, 8'h5A, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C}
        },
        '{
            '{8'h03, 8'h01, 8'h02, 8'h31, 8'h32, 8'h33, 8'h34},
            '{8'h40, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30},
            '{8'h22, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h11},
            '{8'h14, 8'h1B, 8'h2C, 8'h2E, 8'h3F, 8'h13, 8'h3A},
            '{8'h15, 8'h09, 8'h16, 8'h04, 8'h08, 8'h05, 8'h5C}
        }
    };

    typedef enum logic [1:0] {ST_SCAN, ST_CONFIRM, ST_HOLD} t_scan_state;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               valid;
        logic [CODE_W-1:0]  code;
        logic [1:0]         mode;
    } t_key_beat;

    class key_scoreboard;
        t_scan_state        state;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   first_row;
        logic [ROW_W-1:0]   last_row;
        logic [CNT_W-1:0]   confirm_cnt;
        logic [CNT_W-1:0]   match_cnt;
        logic [CNT_W-1:0]   threshold;
        logic [HOLD_W-1:0]  hold_cnt;
        logic [HOLD_W-1:0]  holdoff;
        logic [1:0]         mode;
        t_key_beat          expected_beats [$];
        int                 mismatches;

        function new();
            state       = ST_SCAN;
            col         = '0;
            first_row   = '0;
            last_row    = '0;
            confirm_cnt = '0;
            match_cnt   = '0;
            hold_cnt    = '0;
            mode        = MODE_LOWER;
            holdoff     = 16'd300;
            threshold   = 4'd4;
            mismatches  = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] data);
            if (idx == CFG_HOLDOFF) begin
                holdoff = data;
            end else if (idx == CFG_THRESHOLD) begin
                threshold = data[CNT_W-1:0];
            end
        endfunction

        function void advance_column();
            col = (int'(col) + 1 >= SCAN_COLS) ? '0 : col + 1'b1;
        endfunction

        function void note_sample(logic [ROW_W-1:0] s);
            t_key_beat         beat;
            logic [CODE_W-1:0] key;
            int                row;
            beat = '0;
            case (state)
                ST_HOLD: begin
                    if (hold_cnt != '0) hold_cnt = hold_cnt - 1'b1;
                    if (hold_cnt == '0) state = ST_SCAN;
                    col = '0;
                end
                ST_CONFIRM: begin
                    if (s == last_row) match_cnt = match_cnt + 1'b1;
                    last_row    = s;
                    confirm_cnt = confirm_cnt + 1'b1;
                    if (confirm_cnt >= CONFIRM_LEN) begin
                        if (match_cnt > threshold) begin
                            row = 0;
                            while (row < ROW_W - 1 && !first_row[row]) row++;
                            key = KEY_MAP[mode][row][col];
                            if (key == CODE_SHIFT) begin
                                mode = MODE_SHIFTED;
                            end else if (key == CODE_CAPS) begin
                                mode = MODE_UPPER;
                            end else begin
                                beat.valid = 1'b1;
                                beat.code  = key;
                                mode       = MODE_LOWER;
                            end
                            col      = '0;
                            hold_cnt = holdoff;
                            state    = (holdoff == '0) ? ST_SCAN : ST_HOLD;
                        end else begin
                            advance_column();
                            state = ST_SCAN;
                        end
                    end
                end
                default: begin
                    if ($onehot(s)) begin
                        first_row   = s;
                        last_row    = s;
                        confirm_cnt = '0;
                        match_cnt   = '0;
                        state       = ST_CONFIRM;
                    end else begin
                        advance_column();
                        state = ST_SCAN;
                    end
                end
            endcase
            beat.drive = 7'b1 << col;
            beat.mode  = mode;
            expected_beats.push_back(beat);
        endfunction

        function void check_beat(t_key_beat got);
            t_key_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected beat drive=%h valid=%b code=%h mode=%0d",
                             got.drive, got.valid, got.code, got.mode);
                return;
            end
            want = expected_beats.pop_front();
            if (want.drive !== got.drive || want.valid !== got.valid ||
                want.code !== got.code || want.mode !== got.mode) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: drive/valid/code/mode want %h %b %h %0d got %h %b %h %0d",
                             want.drive, want.valid, want.code, want.mode,
                             got.drive, got.valid, got.code, got.mode);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ROW_W-1:0]     i_row_bits;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [DRIVE_W-1:0]   o_column_drive;
    logic                 o_key_valid;
    logic [CODE_W-1:0]    o_key_code;
    logic [1:0]           o_table_mode;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [HOLD_W-1:0]    i_cfg_data;

    key_scoreboard sb;
    bit            quiet;
    int            samples_counted;
    int            cycles;
    int            stall_left;

    keypad_matrix_scanner u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_row_bits     (i_row_bits),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_column_drive (o_column_drive),
        .o_key_valid    (o_key_valid),
        .o_key_code     (o_key_code),
        .o_table_mode   (o_table_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (quiet || stall_left == 0) begin
            i_out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) < 60);
            stall_left = quiet ? 0 :
                         (($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 3));
        end else begin
            stall_left--;
        end
    end

    // One result beat is checked per handshake on the output side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat(t_key_beat'{o_column_drive, o_key_valid, o_key_code, o_table_mode});
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic [ROW_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row_bits <= s;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (sb.state != ST_HOLD) samples_counted++;
        sb.note_sample(s);
    endtask

    task automatic press_key(input int row, input int col, input int bounce_pct);
        logic [ROW_W-1:0] s;
        while (!(sb.state == ST_SCAN && sb.col == col)) begin
            if (sb.state != ST_SCAN)
                s = 5'($urandom);
            else if ($urandom_range(0, 3) == 0)
                s = 5'($urandom) | (5'b00011 << $urandom_range(0, 3));
            else
                s = '0;
            send_sample(s);
        end
        send_sample(5'b1 << row);
        repeat (CONFIRM_LEN)
            send_sample(($urandom_range(0, 99) < bounce_pct) ? 5'($urandom) : 5'b1 << row);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.configure(idx, data);
    endtask

    task automatic set_config(input logic [HOLD_W-1:0] hold, input logic [CNT_W-1:0] thr);
        wait_drained();
        write_reg(CFG_HOLDOFF, hold);
        write_reg(CFG_THRESHOLD, {12'($urandom), thr});
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int thr_plan [6];
        int phase_start;
        int bounce;
        thr_plan = '{7, 2, 8, 0, 15, 5};
        sb = new();
        quiet = 1'b0;
        samples_counted = 0;
        stall_left = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_row_bits  <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HOLDOFF;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: multi-bit rows, column wrap, reset settings, modifier keys.
        send_sample(5'h1F);
        send_sample(5'h11);
        press_key(0, 3, 0);
        wait_drained();
        write_reg(CFG_SPARE, 16'hFFFF);
        set_config(16'd0, 4'd0);
        press_key(4, 2, 0);
        press_key(1, 0, 0);
        press_key(4, 3, 0);
        press_key(3, 6, 0);
        press_key(4, 3, 0);
        press_key(4, 2, 0);
        press_key(4, 6, 0);
        press_key(2, 1, 100);

        for (int p = 0; p < 6; p++) begin
            set_config(16'($urandom_range(0, 12)), 4'(thr_plan[p]));
            quiet = (p == 3);
            phase_start = samples_counted;
            while (samples_counted - phase_start < 30) begin
                if ($urandom_range(0, 99) < 75) begin
                    bounce = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 50) : 0;
                    press_key($urandom_range(0, 4), $urandom_range(0, 6), bounce);
                end else begin
                    repeat ($urandom_range(1, 6)) send_sample(5'($urandom));
                end
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
